FILE: src/bounded_substring_search_defines.svh
// Assertion macros used by the checker file.
`ifndef BOUNDED_SUBSTRING_SEARCH_DEFINES_SVH
`define BOUNDED_SUBSTRING_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bss check failed (same cycle)");

// Next-cycle implication, disabled while in reset.
`define BSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bss check failed (next cycle)");

`endif

FILE: src/bss_pkg.sv
// Shared types, constants and helpers for the bounded substring search.
`timescale 1ns / 1ps
package bss_pkg;

  localparam int NEEDLE_MAX = 8;
  localparam int INDEX_BITS = 16;
  localparam int LEN_BITS   = $clog2(NEEDLE_MAX + 1);
  localparam int CFG_LEN_BITS = 4;
  localparam int MAX_BITS   = 16;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [7:0] NUL_BYTE = 8'h00;
  localparam logic [7:0] UPPER_A  = 8'h41;
  localparam logic [7:0] UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef logic [7:0] byte_t;
  typedef logic [NEEDLE_MAX-1:0][7:0] window_t;
  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [LEN_BITS-1:0] len_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_NEEDLE_BYTES  = 2'd0,
    CFG_NEEDLE_LENGTH = 2'd1,
    CFG_MAX_LENGTH    = 2'd2,
    CFG_IGNORE_CASE   = 2'd3
  } cfg_reg_t;

  function automatic byte_t fold_byte(input byte_t b, input logic ignore_case);
    byte_t r;
    r = b;
    if (ignore_case && b >= UPPER_A && b <= UPPER_Z) begin
      r = b | CASE_BIT;
    end
    return r;
  endfunction

endpackage

FILE: src/bss_window_match.sv
// Parallel needle compare against the byte window, one result per needle length.
`timescale 1ns / 1ps
module bss_window_match (
  input  bss_pkg::window_t window,
  input  bss_pkg::window_t needle,
  input  bss_pkg::len_t    len,
  input  logic             ignore_case,
  output logic             hit
);
  import bss_pkg::*;

  logic [NEEDLE_MAX:0] hit_by_len;

  // needle byte k lines up with window entry len-1-k (entry 0 is the newest byte)
  always_comb begin
    hit_by_len = '0;
    hit_by_len[0] = 1'b1;
    for (int l = 1; l <= NEEDLE_MAX; l++) begin
      hit_by_len[l] = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (fold_byte(needle[k], ignore_case) != fold_byte(window[l-1-k], ignore_case)) begin
          hit_by_len[l] = 1'b0;
        end
      end
    end
  end

  assign hit = hit_by_len[len];

endmodule

FILE: src/bounded_substring_search.sv
// Latency: a result appears in the cycle after its text item is accepted.
// Throughput: one text item per cycle; the combinational window compare and index
// update set that figure. Input stalls only while a result sits stalled in the output
// register; a result taken in the same cycle frees the slot for the next item.
// Reset (synchronous) clears the search state, the config registers and the output
// valid; no clearing pass is needed.
`timescale 1ns / 1ps
module bounded_substring_search (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bss_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               text_valid,
  output logic                               text_stall,
  input  logic [7:0]                         text_byte,
  input  logic                               start_req,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic                               match_found,
  output logic [bss_pkg::INDEX_BITS-1:0]     match_position,
  output logic                               search_done
);
  import bss_pkg::*;

  window_t                 needle_bytes;
  logic [CFG_LEN_BITS-1:0] needle_length;
  logic [MAX_BITS-1:0]     max_length;
  logic                    ignore_case;

  window_t recent_bytes, recent_bytes_next;
  index_t  byte_index, byte_index_next;
  logic    finished, finished_next;
  logic    found_flag, found_flag_next;
  index_t  found_offset, found_offset_next;

  window_t cur_window, window_shift;
  index_t  cur_index;
  logic    cur_finished, cur_found;
  index_t  cur_offset;
  len_t    len_eff;
  logic    hit;
  logic [INDEX_BITS:0] index_inc;
  logic [INDEX_BITS:0] len_ext;
  logic [INDEX_BITS:0] max_ext;
  logic    accept;

  assign cfg_ready  = 1'b1;
  assign text_stall = result_valid && result_stall;
  assign accept     = text_valid && !text_stall;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      needle_bytes  <= '0;
      needle_length <= '0;
      max_length    <= '0;
      ignore_case   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_NEEDLE_BYTES:  needle_bytes  <= window_t'(cfg_data[8*NEEDLE_MAX-1:0]);
        CFG_NEEDLE_LENGTH: needle_length <= cfg_data[CFG_LEN_BITS-1:0];
        CFG_MAX_LENGTH:    max_length    <= cfg_data[MAX_BITS-1:0];
        CFG_IGNORE_CASE:   ignore_case   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // lengths above the window size are clamped
  assign len_eff = ({1'b0, needle_length} > (CFG_LEN_BITS+1)'(NEEDLE_MAX)) ?
                   LEN_BITS'(NEEDLE_MAX) : LEN_BITS'(needle_length);

  // a start item clears the search before its byte is processed
  assign cur_window   = start_req ? '0 : recent_bytes;
  assign cur_index    = start_req ? '0 : byte_index;
  assign cur_finished = start_req ? 1'b0 : finished;
  assign cur_found    = start_req ? 1'b0 : found_flag;
  assign cur_offset   = start_req ? '0 : found_offset;

  assign window_shift = {cur_window[NEEDLE_MAX-2:0], text_byte};
  assign index_inc    = {1'b0, cur_index} + (INDEX_BITS+1)'(1);
  assign len_ext      = (INDEX_BITS+1)'(len_eff);
  assign max_ext      = (INDEX_BITS+1)'(max_length);

  bss_window_match u_match (
    .window      (window_shift),
    .needle      (needle_bytes),
    .len         (len_eff),
    .ignore_case (ignore_case),
    .hit         (hit)
  );

  always_comb begin
    recent_bytes_next = cur_window;
    byte_index_next   = cur_index;
    finished_next     = cur_finished;
    found_flag_next   = cur_found;
    found_offset_next = cur_offset;
    if (!cur_finished) begin
      priority if (text_byte == NUL_BYTE) begin
        finished_next = 1'b1;
      end else if (len_eff == '0) begin
        // empty needle matches at the start
        found_flag_next   = 1'b1;
        found_offset_next = '0;
        finished_next     = 1'b1;
      end else if ((INDEX_BITS+1)'(cur_index) >= max_ext) begin
        finished_next = 1'b1;
      end else begin
        recent_bytes_next = window_shift;
        priority if (index_inc >= len_ext && hit) begin
          found_flag_next   = 1'b1;
          found_offset_next = INDEX_BITS'(index_inc - len_ext);
          finished_next     = 1'b1;
        end else if (index_inc >= max_ext) begin
          finished_next = 1'b1;
        end else if (cur_index != '1) begin
          byte_index_next = index_inc[INDEX_BITS-1:0];
        end else begin
          byte_index_next = cur_index;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes <= '0;
      byte_index   <= '0;
      finished     <= 1'b0;
      found_flag   <= 1'b0;
      found_offset <= '0;
    end else if (accept) begin
      recent_bytes <= recent_bytes_next;
      byte_index   <= byte_index_next;
      finished     <= finished_next;
      found_flag   <= found_flag_next;
      found_offset <= found_offset_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      match_found    <= found_flag_next;
      match_position <= found_flag_next ? found_offset_next : '0;
      search_done    <= finished_next;
    end
  end

endmodule

FILE: src/bss_checker.sv
// Port-level checks for the bounded substring search, bound to the top level.
`timescale 1ns / 1ps
`include "bounded_substring_search_defines.svh"
module bss_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           text_valid,
  input logic                           text_stall,
  input logic [7:0]                     text_byte,
  input logic                           start_req,
  input logic                           result_valid,
  input logic                           match_found,
  input logic [bss_pkg::INDEX_BITS-1:0] match_position,
  input logic                           search_done
);
  import bss_pkg::*;

  logic nul_start_item;

  assign nul_start_item = text_valid && !text_stall && start_req && text_byte == NUL_BYTE;

  // a match always ends the search
  `BSS_ASSERT_NOW(a_found_done, result_valid && match_found, search_done)
  // no match reports offset zero
  `BSS_ASSERT_NOW(a_pos_zero, result_valid && !match_found, match_position == '0)
  // every accepted item gives a result next cycle
  `BSS_ASSERT_NEXT(a_item_result, text_valid && !text_stall, result_valid)
  // a new haystack that opens with NUL ends at once with no match
  `BSS_ASSERT_NEXT(a_nul_start, nul_start_item, result_valid && search_done && !match_found)

endmodule

bind bounded_substring_search bss_checker u_bss_checker (.*);
